### hdl/rit_pkg.sv
// ----------------------------------------------------------------------------
// rit_pkg
// Shared types and constants of the reassembly interval tracker.
// ----------------------------------------------------------------------------
package rit_pkg;

   localparam int MAX_BLOCKS = 8;
   localparam int IDX_W      = $clog2(MAX_BLOCKS + 1);   // holds 0..MAX_BLOCKS
   localparam int ADR_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int PIECE_MAX  = MAX_BLOCKS + 1;
   localparam int PCNT_W     = $clog2(PIECE_MAX + 1);

   localparam logic OP_FILL  = 1'b0;
   localparam logic OP_SLIDE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [63:0] range_begin;
      logic [63:0] range_end;
      logic [31:0] slide_request;
   } req_type;

   typedef struct packed {
      logic        has_piece;
      logic [63:0] piece_begin;
      logic [63:0] piece_end;
      logic [31:0] slid_amount;
      logic [31:0] slidable_now;
      logic        table_full;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      TBL_NOP   = 2'd0,
      TBL_MERGE = 2'd1,
      TBL_POP   = 2'd2,
      TBL_TRIM  = 2'd3
   } tbl_cmd_type;

   typedef struct packed {
      tbl_cmd_type       cmd;
      logic [IDX_W-1:0]  idx;
      logic [63:0]       pb;
      logic [63:0]       pe;
   } tbl_req_type;

endpackage

### hdl/reassembly_interval_tracker.sv
// ----------------------------------------------------------------------------
// reassembly_interval_tracker
// Interval table of received stream ranges with fill and slide requests.
// ----------------------------------------------------------------------------
// A slide passes S_SLEN, S_SLIDE and S_HEAD before S_EMIT; a fill whose range
// clips to empty passes S_LIM, S_CLIP and S_HEAD. Any other fill also scans the
// table (S_SCAN, S_FINAL), then searches and merges each piece (S_MSRCH, S_MAPPLY).
// Only one request is handled at a time; the single compare/update datapath
// walks the table one entry per cycle.
// Synchronous active-high reset clears the table count, the left edge, the
// output valid flag and loads a window size of 65536.
module reassembly_interval_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rit_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rit_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);
   import rit_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_LIM    = 11'b000_0000_0010,
      S_CLIP   = 11'b000_0000_0100,
      S_SCAN   = 11'b000_0000_1000,
      S_FINAL  = 11'b000_0001_0000,
      S_MSRCH  = 11'b000_0010_0000,
      S_MAPPLY = 11'b000_0100_0000,
      S_SLEN   = 11'b000_1000_0000,
      S_SLIDE  = 11'b001_0000_0000,
      S_HEAD   = 11'b010_0000_0000,
      S_EMIT   = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       win_ff, win_in;
   logic [63:0]       left_ff, left_in;
   logic [63:0]       rb_ff, rb_in, re_ff, re_in;
   logic [31:0]       sreq_ff, sreq_in;
   logic [63:0]       lim_ff, lim_in;
   logic [63:0]       b_ff, b_in, e_ff, e_in, cur_ff, cur_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [PCNT_W-1:0] npc_ff, npc_in, ptr_ff, ptr_in;
   logic [31:0]       slid_ff, slid_in, slen_ff, slen_in;
   logic [63:0]       pbeg_ff [PIECE_MAX];
   logic [63:0]       pend_ff [PIECE_MAX];
   logic              stored_ff [PIECE_MAX];
   logic              buf_we, sto_we;
   logic [63:0]       buf_b, buf_e;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   tbl_req_type       tbl_req;
   logic [63:0]       rd_start, rd_stop, head_start, head_stop;
   logic [IDX_W-1:0]  count;
   logic              merge_ok;
   logic [64:0]       lim_sum;
   logic [63:0]       head_diff;
   logic [31:0]       head_len, act;
   logic              out_free;

   rit_table u_table (
      .clock      (clock),
      .reset      (reset),
      .tbl_req    (tbl_req),
      .rd_idx     (i_ff[ADR_W-1:0]),
      .rd_start   (rd_start),
      .rd_stop    (rd_stop),
      .head_start (head_start),
      .head_stop  (head_stop),
      .count      (count),
      .merge_ok   (merge_ok)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // length of the interval that starts at the left edge, saturated
   assign head_diff = head_stop - head_start;
   assign head_len  = (count == '0 || head_start != left_ff) ? 32'd0 :
                      (head_diff[63:32] != '0) ? 32'hFFFF_FFFF : head_diff[31:0];
   assign lim_sum   = {1'b0, left_ff} + {33'd0, win_ff};
   assign act       = (sreq_ff < slen_ff) ? sreq_ff : slen_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      win_in       = csr_we ? csr_wdata : win_ff;
      left_in      = left_ff;
      rb_in        = rb_ff;
      re_in        = re_ff;
      sreq_in      = sreq_ff;
      lim_in       = lim_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      cur_in       = cur_ff;
      i_in         = i_ff;
      npc_in       = npc_ff;
      ptr_in       = ptr_ff;
      slid_in      = slid_ff;
      slen_in      = slen_ff;
      buf_we       = 1'b0;
      sto_we       = 1'b0;
      buf_b        = cur_ff;
      buf_e        = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      tbl_req.cmd  = TBL_NOP;
      tbl_req.idx  = i_ff;
      tbl_req.pb   = pbeg_ff[ptr_ff];
      tbl_req.pe   = pend_ff[ptr_ff];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rb_in   = req_data.range_begin;
               re_in   = req_data.range_end;
               sreq_in = req_data.slide_request;
               npc_in  = '0;
               slid_in = '0;
               state_in = (req_data.op == OP_SLIDE) ? S_SLEN : S_LIM;
            end
         end
         S_LIM: begin
            lim_in   = lim_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : lim_sum[63:0];
            state_in = S_CLIP;
         end
         S_CLIP: begin
            b_in   = (rb_ff > left_ff) ? rb_ff : left_ff;
            e_in   = (re_ff < lim_ff) ? re_ff : lim_ff;
            cur_in = b_in;
            i_in   = '0;
            state_in = (b_in < e_in) ? S_SCAN : S_HEAD;
         end
         // walk the table and collect uncovered gaps
         S_SCAN: begin
            if (i_ff < count && cur_ff < e_ff) begin
               if (rd_stop <= cur_ff) begin
                  i_in = i_ff + IDX_W'(1);
               end else if (rd_start >= e_ff) begin
                  state_in = S_FINAL;
               end else begin
                  if (rd_start > cur_ff) begin
                     buf_we = 1'b1;
                     buf_e  = rd_start;
                     npc_in = npc_ff + PCNT_W'(1);
                  end
                  cur_in = rd_stop;
                  i_in   = i_ff + IDX_W'(1);
               end
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            npc_in = npc_ff;
            if (cur_ff < e_ff && npc_ff <= PCNT_W'(MAX_BLOCKS)) begin
               buf_we = 1'b1;
               npc_in = npc_ff + PCNT_W'(1);
            end
            ptr_in = '0;
            i_in   = '0;
            state_in = (npc_in == '0) ? S_HEAD : S_MSRCH;
         end
         // find the insertion point of the current piece
         S_MSRCH: begin
            if (i_ff < count && rd_start <= pbeg_ff[ptr_ff]) begin
               i_in = i_ff + IDX_W'(1);
            end else begin
               state_in = S_MAPPLY;
            end
         end
         S_MAPPLY: begin
            tbl_req.cmd = TBL_MERGE;
            sto_we = 1'b1;
            ptr_in = ptr_ff + PCNT_W'(1);
            i_in   = '0;
            state_in = (ptr_in == npc_ff) ? S_HEAD : S_MSRCH;
         end
         S_SLEN: begin
            slen_in  = head_len;
            state_in = S_SLIDE;
         end
         // advance the left edge and trim or drop the head entry
         S_SLIDE: begin
            slid_in = act;
            if (act != '0) begin
               left_in    = left_ff + {32'd0, act};
               tbl_req.pb = left_in;
               tbl_req.cmd = (act == slen_ff) ? TBL_POP : TBL_TRIM;
            end
            state_in = S_HEAD;
         end
         S_HEAD: begin
            slen_in  = head_len;
            ptr_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.slid_amount  = slid_ff;
               rsp_in.slidable_now = slen_ff;
               if (npc_ff == '0) begin
                  rsp_in.has_piece   = 1'b0;
                  rsp_in.piece_begin = '0;
                  rsp_in.piece_end   = '0;
                  rsp_in.table_full  = 1'b0;
                  rsp_in.last        = 1'b1;
               end else begin
                  rsp_in.has_piece   = stored_ff[ptr_ff];
                  rsp_in.piece_begin = pbeg_ff[ptr_ff];
                  rsp_in.piece_end   = pend_ff[ptr_ff];
                  rsp_in.table_full  = !stored_ff[ptr_ff];
                  rsp_in.last        = (ptr_ff + PCNT_W'(1) == npc_ff);
               end
               ptr_in = ptr_ff + PCNT_W'(1);
               if (rsp_in.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold piece buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         pbeg_ff[npc_ff] <= buf_b;
         pend_ff[npc_ff] <= buf_e;
      end
      if (sto_we) begin
         stored_ff[ptr_ff] <= merge_ok;
      end
   end

   // advance datapath and control registers
   always_ff @(posedge clock) begin
      rb_ff   <= rb_in;
      re_ff   <= re_in;
      sreq_ff <= sreq_in;
      lim_ff  <= lim_in;
      b_ff    <= b_in;
      e_ff    <= e_in;
      cur_ff  <= cur_in;
      slid_ff <= slid_in;
      slen_ff <= slen_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         win_ff       <= 32'd65536;
         left_ff      <= '0;
         i_ff         <= '0;
         npc_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         left_ff      <= left_in;
         i_ff         <= i_in;
         npc_ff       <= npc_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/rit_table.sv
// ----------------------------------------------------------------------------
// rit_table
// Sorted interval table: one read port, merge of one piece, pop and trim
// of the head entry.
// ----------------------------------------------------------------------------
module rit_table (
   input  logic                       clock,
   input  logic                       reset,
   input  rit_pkg::tbl_req_type       tbl_req,
   input  logic [rit_pkg::ADR_W-1:0]  rd_idx,
   output logic [63:0]                rd_start,
   output logic [63:0]                rd_stop,
   output logic [63:0]                head_start,
   output logic [63:0]                head_stop,
   output logic [rit_pkg::IDX_W-1:0]  count,
   output logic                       merge_ok
);
   import rit_pkg::*;

   logic [63:0]      start_ff [MAX_BLOCKS];
   logic [63:0]      stop_ff  [MAX_BLOCKS];
   logic [63:0]      start_in [MAX_BLOCKS];
   logic [63:0]      stop_in  [MAX_BLOCKS];
   logic [IDX_W-1:0] count_ff, count_in;

   logic [ADR_W-1:0] idx_a, idx_m1;
   logic             left, right, full;

   assign rd_start   = start_ff[rd_idx];
   assign rd_stop    = stop_ff[rd_idx];
   assign head_start = start_ff[0];
   assign head_stop  = stop_ff[0];
   assign count      = count_ff;

   // neighbor tests for the piece at the insertion point
   assign idx_a  = tbl_req.idx[ADR_W-1:0];
   assign idx_m1 = ADR_W'(tbl_req.idx - IDX_W'(1));
   assign left   = (tbl_req.idx != '0) && (stop_ff[idx_m1] == tbl_req.pb);
   assign right  = (tbl_req.idx < count_ff) && (start_ff[idx_a] == tbl_req.pe);
   assign full   = (count_ff >= IDX_W'(MAX_BLOCKS));
   assign merge_ok = left || right || !full;

   // next table contents
   always_comb begin
      count_in = count_ff;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         start_in[k] = start_ff[k];
         stop_in[k]  = stop_ff[k];
      end
      case (tbl_req.cmd)
         TBL_MERGE: begin
            if (left && right) begin
               for (int k = 0; k < MAX_BLOCKS; k++) begin
                  if (IDX_W'(k + 1) == tbl_req.idx) begin
                     stop_in[k] = stop_ff[idx_a];
                  end
                  if (IDX_W'(k) >= tbl_req.idx && k + 1 < MAX_BLOCKS) begin
                     if (IDX_W'(k + 1) < count_ff) begin
                        start_in[k] = start_ff[k + 1];
                        stop_in[k]  = stop_ff[k + 1];
                     end
                  end
               end
               count_in = count_ff - IDX_W'(1);
            end else if (left) begin
               stop_in[idx_m1] = tbl_req.pe;
            end else if (right) begin
               start_in[idx_a] = tbl_req.pb;
            end else if (!full) begin
               for (int k = 1; k < MAX_BLOCKS; k++) begin
                  if (IDX_W'(k) > tbl_req.idx && IDX_W'(k) <= count_ff) begin
                     start_in[k] = start_ff[k - 1];
                     stop_in[k]  = stop_ff[k - 1];
                  end
               end
               start_in[idx_a] = tbl_req.pb;
               stop_in[idx_a]  = tbl_req.pe;
               count_in = count_ff + IDX_W'(1);
            end
         end
         TBL_POP: begin
            for (int k = 0; k + 1 < MAX_BLOCKS; k++) begin
               start_in[k] = start_ff[k + 1];
               stop_in[k]  = stop_ff[k + 1];
            end
            count_in = count_ff - IDX_W'(1);
         end
         TBL_TRIM: begin
            start_in[0] = tbl_req.pb;
         end
         default: begin
         end
      endcase
   end

   // hold entry payload, reset the count
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         start_ff[k] <= start_in[k];
         stop_ff[k]  <= stop_in[k];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
